### rtl/vlpc_pkg.sv
// Shared types, lamp colors and helper functions for the vehicle light
// pattern controller. No dependencies.
`default_nettype none

package vlpc_pkg;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Proximity overlay for one front lamp, handed to the blend stage.
  typedef struct packed {
    logic        active;
    logic [12:0] closeness;
    logic [7:0]  ov_red;
    logic [7:0]  ov_green;
  } blend_t;

  localparam rgb_t C_TURN     = '{blue: 8'd0,   green: 8'd140, red: 8'd255};
  localparam rgb_t C_REV      = '{blue: 8'd255, green: 8'd255, red: 8'd255};
  localparam rgb_t C_HEAD_ACT = '{blue: 8'd240, green: 8'd255, red: 8'd255};
  localparam rgb_t C_HEAD_DBG = '{blue: 8'd255, green: 8'd255, red: 8'd0};
  localparam rgb_t C_LOCKED   = '{blue: 8'd32,  green: 8'd32,  red: 8'd255};
  localparam rgb_t C_TAIL_DBG = '{blue: 8'd255, green: 8'd120, red: 8'd0};
  localparam rgb_t C_TAIL_RED = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
  localparam rgb_t C_WIFI     = '{blue: 8'd255, green: 8'd180, red: 8'd0};
  localparam rgb_t C_OFF      = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};

  localparam logic [1:0] MODE_DEBUG  = 2'd1;
  localparam logic [1:0] MODE_LOCKED = 2'd2;

  localparam logic [1:0] REG_FEATURE_EN = 2'd0;
  localparam logic [1:0] REG_BLINK_PER  = 2'd1;
  localparam logic [1:0] REG_ALERT_RC   = 2'd2;
  localparam logic [1:0] REG_ALERT_WIFI = 2'd3;

  localparam logic [15:0] BLINK_DEFAULT_MS = 16'd500;
  localparam logic [31:0] ALERT_STEP_MS    = 32'd180;
  localparam logic [12:0] RANGE_FAR        = 13'd4096;
  localparam logic [12:0] RANGE_HALF       = 13'd2048;
  localparam logic [12:0] CLOSE_MIN        = 13'd41;
  localparam logic signed [15:0] STEER_THRESH = 16'sd4096;
  localparam logic signed [15:0] REV_THRESH   = -16'sd2458;

  function automatic logic [31:0] hazard_len(input logic [1:0] step);
    logic [31:0] len;
    case (step)
      2'd3:    len = 32'd450;
      default: len = 32'd150;
    endcase
    return len;
  endfunction

  // Green-to-red gradient: 255*x/2048 done as (x<<8 - x) >> 11.
  function automatic blend_t front_overlay(input logic [12:0] range);
    logic [12:0] r_sat;
    logic [12:0] c;
    logic [12:0] x;
    logic [20:0] t;
    blend_t      b;
    r_sat = (range > RANGE_FAR) ? RANGE_FAR : range;
    c = RANGE_FAR - r_sat;
    x = (c <= RANGE_HALF) ? c : (RANGE_FAR - c);
    t = {x, 8'd0} - {8'd0, x};
    b.active    = (c >= CLOSE_MIN);
    b.closeness = c;
    if (c <= RANGE_HALF) begin
      b.ov_red   = t[18:11];
      b.ov_green = 8'd255;
    end else begin
      b.ov_red   = 8'd255;
      b.ov_green = t[18:11];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/vlpc_front_blend.sv
// Proximity blend and output register for one front lamp.
// Depends on vlpc_pkg.
`default_nettype none

module vlpc_front_blend (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire vlpc_pkg::rgb_t   base,
  input  wire vlpc_pkg::blend_t blend,
  output vlpc_pkg::rgb_t        lamp
);

  logic [12:0]    far_w;
  logic [20:0]    br, bg, bb, or_p, og_p;
  logic [21:0]    sr, sg, sb;
  vlpc_pkg::rgb_t mixed;

  assign far_w = vlpc_pkg::RANGE_FAR - blend.closeness;
  assign br    = 21'(base.red)   * 21'(far_w);
  assign bg    = 21'(base.green) * 21'(far_w);
  assign bb    = 21'(base.blue)  * 21'(far_w);
  assign or_p  = 21'(blend.ov_red)   * 21'(blend.closeness);
  assign og_p  = 21'(blend.ov_green) * 21'(blend.closeness);
  assign sr    = 22'(br) + 22'(or_p);
  assign sg    = 22'(bg) + 22'(og_p);
  assign sb    = 22'(bb);

  // sums do not exceed 255*4096, so the quotient fits 8 bits
  assign mixed.red   = sr[19:12];
  assign mixed.green = sg[19:12];
  assign mixed.blue  = sb[19:12];

  always_ff @(posedge clk) begin
    if (load) begin
      lamp <= blend.active ? mixed : base;
    end
  end

endmodule

`default_nettype wire

### rtl/vehicle_light_pattern_controller_core.sv
// Top level of the vehicle light pattern controller: stream ports, timers,
// pattern selection and the two-stage result pipeline.
// Depends on vlpc_pkg and vlpc_front_blend.
`default_nettype none

// Takes one sample word per cycle and returns at most one lamp word for it
// via the stage one and output registers. Stage one picks the pattern and
// updates the blink, hazard and alert timers; stage two does the proximity
// blend of the front lamps, two multiplies each for red and green, one for
// blue. Throughput is one word per cycle; ready drops only while the output
// register is full and not taken. Samples taken while the feature is off and
// hazard is clear produce no output word and leave all timers untouched.
module vehicle_light_pattern_controller_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // now_ms[31:0], hazard[32], status_mode[34:33], throttle[50:35],
  // steering[66:51], range_left[79:67], range_right[92:80],
  // rc_link_up[93], wifi_link_up[94], zero[95]
  input  wire logic [95:0] s_tdata,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // front_left rgb[23:0], front_right rgb[47:24], rear_left rgb[71:48],
  // rear_right rgb[95:72]; each lamp red, green, blue from the low byte up
  output      logic [95:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [1:0] ALERT_NONE = 2'd0;
  localparam logic [1:0] ALERT_RC   = 2'd1;
  localparam logic [1:0] ALERT_WIFI = 2'd2;

  // config
  logic        feature_enabled;
  logic [15:0] blink_period_ms;
  logic        alert_on_rc;
  logic        alert_on_wifi;

  // timers
  logic        blink_on, blink_on_next;
  logic [31:0] blink_toggle_time, blink_toggle_time_next;
  logic [1:0]  hazard_step, hazard_step_next;
  logic [31:0] hazard_step_start, hazard_step_start_next;
  logic [1:0]  alert_step, alert_step_next;
  logic [31:0] alert_step_start, alert_step_start_next;

  // input fields
  logic [31:0]        now_ms;
  logic               hazard;
  logic [1:0]         status_mode;
  logic signed [15:0] throttle;
  logic signed [15:0] steering;
  logic [12:0]        range_left;
  logic [12:0]        range_right;
  logic               rc_link_up;
  logic               wifi_link_up;

  assign now_ms       = s_tdata[31:0];
  assign hazard       = s_tdata[32];
  assign status_mode  = s_tdata[34:33];
  assign throttle     = s_tdata[50:35];
  assign steering     = s_tdata[66:51];
  assign range_left   = s_tdata[79:67];
  assign range_right  = s_tdata[92:80];
  assign rc_link_up   = s_tdata[93];
  assign wifi_link_up = s_tdata[94];

  // pipeline control
  logic a_valid;
  logic advance_b;
  logic s_accept;
  logic produce;

  assign advance_b = a_valid && (!m_tvalid || m_tready);
  assign s_tready  = !a_valid || advance_b;
  assign s_accept  = s_tvalid && s_tready;
  assign produce   = feature_enabled || hazard;

  // stage one logic
  logic [15:0]      period;
  logic             blink_due, haz_due, alert_due;
  logic [1:0]       alert_kind;
  vlpc_pkg::rgb_t   fl, fr, rl, rr, head, tail, blinkc;
  logic             blend_en;
  vlpc_pkg::blend_t ov_l, ov_r, bl_l, bl_r;

  assign ov_l = vlpc_pkg::front_overlay(range_left);
  assign ov_r = vlpc_pkg::front_overlay(range_right);

  always_comb begin
    period    = (blink_period_ms == 16'd0) ? vlpc_pkg::BLINK_DEFAULT_MS : blink_period_ms;
    blink_due = (now_ms - blink_toggle_time) >= {17'd0, period[15:1]};
    blink_on_next          = blink_on ^ blink_due;
    blink_toggle_time_next = blink_due ? now_ms : blink_toggle_time;

    haz_due = (now_ms - hazard_step_start) >= vlpc_pkg::hazard_len(hazard_step);
    if (hazard) begin
      hazard_step_next       = haz_due ? hazard_step + 2'd1 : hazard_step;
      hazard_step_start_next = haz_due ? now_ms : hazard_step_start;
    end else begin
      hazard_step_next       = 2'd0;
      hazard_step_start_next = now_ms;
    end

    if (alert_on_rc && !rc_link_up) begin
      alert_kind = ALERT_RC;
    end else if (alert_on_wifi && !wifi_link_up) begin
      alert_kind = ALERT_WIFI;
    end else begin
      alert_kind = ALERT_NONE;
    end
    alert_due = (now_ms - alert_step_start) >= vlpc_pkg::ALERT_STEP_MS;
    if (hazard) begin
      alert_step_next       = alert_step;
      alert_step_start_next = alert_step_start;
    end else if (alert_kind != ALERT_NONE) begin
      alert_step_next       = alert_due ? alert_step + 2'd1 : alert_step;
      alert_step_start_next = alert_due ? now_ms : alert_step_start;
    end else begin
      alert_step_next       = 2'd0;
      alert_step_start_next = now_ms;
    end

    case (status_mode)
      vlpc_pkg::MODE_DEBUG: begin
        head = vlpc_pkg::C_HEAD_DBG;
        tail = vlpc_pkg::C_TAIL_DBG;
      end
      vlpc_pkg::MODE_LOCKED: begin
        head = vlpc_pkg::C_LOCKED;
        tail = vlpc_pkg::C_LOCKED;
      end
      default: begin
        head = vlpc_pkg::C_HEAD_ACT;
        tail = vlpc_pkg::C_TAIL_RED;
      end
    endcase
    blinkc   = blink_on_next ? vlpc_pkg::C_TURN : vlpc_pkg::C_OFF;
    blend_en = 1'b0;

    if (hazard) begin
      fl = (hazard_step_next[0] == 1'b0) ? vlpc_pkg::C_TURN : vlpc_pkg::C_OFF;
      fr = fl;
      rl = fl;
      rr = fl;
    end else if (alert_kind == ALERT_RC) begin
      fl = (alert_step_next[0] == 1'b0) ? vlpc_pkg::C_TURN : vlpc_pkg::C_OFF;
      rl = fl;
      fr = (alert_step_next[0] == 1'b0) ? vlpc_pkg::C_OFF : vlpc_pkg::C_TURN;
      rr = fr;
    end else if (alert_kind == ALERT_WIFI) begin
      fl = (alert_step_next[1] == 1'b0) ? vlpc_pkg::C_WIFI : vlpc_pkg::C_OFF;
      fr = fl;
      rl = (alert_step_next[1] == 1'b0) ? vlpc_pkg::C_OFF : vlpc_pkg::C_WIFI;
      rr = rl;
    end else begin
      blend_en = 1'b1;
      fl = head;
      fr = head;
      rl = tail;
      rr = tail;
      if (throttle <= vlpc_pkg::REV_THRESH) begin
        rl = vlpc_pkg::C_REV;
        rr = vlpc_pkg::C_REV;
      end
      if (steering < -vlpc_pkg::STEER_THRESH) begin
        fl = blinkc;
        rl = blinkc;
      end else if (steering > vlpc_pkg::STEER_THRESH) begin
        fr = blinkc;
        rr = blinkc;
      end
    end

    bl_l = ov_l;
    bl_r = ov_r;
    bl_l.active = ov_l.active && blend_en;
    bl_r.active = ov_r.active && blend_en;
  end

  // config and timer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      feature_enabled   <= 1'b1;
      blink_period_ms   <= vlpc_pkg::BLINK_DEFAULT_MS;
      alert_on_rc       <= 1'b1;
      alert_on_wifi     <= 1'b1;
      blink_on          <= 1'b0;
      blink_toggle_time <= 32'd0;
      hazard_step       <= 2'd0;
      hazard_step_start <= 32'd0;
      alert_step        <= 2'd0;
      alert_step_start  <= 32'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vlpc_pkg::REG_FEATURE_EN: feature_enabled <= cfg_data[0];
          vlpc_pkg::REG_BLINK_PER:  blink_period_ms <= cfg_data;
          vlpc_pkg::REG_ALERT_RC:   alert_on_rc     <= cfg_data[0];
          vlpc_pkg::REG_ALERT_WIFI: alert_on_wifi   <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_accept && produce) begin
        blink_on          <= blink_on_next;
        blink_toggle_time <= blink_toggle_time_next;
        hazard_step       <= hazard_step_next;
        hazard_step_start <= hazard_step_start_next;
        alert_step        <= alert_step_next;
        alert_step_start  <= alert_step_start_next;
      end
    end
  end

  // stage one register
  vlpc_pkg::rgb_t   a_fl, a_fr, a_rl, a_rr;
  vlpc_pkg::blend_t a_bl_l, a_bl_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_accept) begin
      a_valid <= produce;
    end else if (advance_b) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      a_fl   <= fl;
      a_fr   <= fr;
      a_rl   <= rl;
      a_rr   <= rr;
      a_bl_l <= bl_l;
      a_bl_r <= bl_r;
    end
  end

  // stage two: blend and output register
  vlpc_pkg::rgb_t o_fl, o_fr, o_rl, o_rr;

  vlpc_front_blend u_blend_left (
    .clk   (clk),
    .load  (advance_b),
    .base  (a_fl),
    .blend (a_bl_l),
    .lamp  (o_fl)
  );

  vlpc_front_blend u_blend_right (
    .clk   (clk),
    .load  (advance_b),
    .base  (a_fr),
    .blend (a_bl_r),
    .lamp  (o_fr)
  );

  always_ff @(posedge clk) begin
    if (advance_b) begin
      o_rl <= a_rl;
      o_rr <= a_rr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance_b) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {o_rr, o_rl, o_fr, o_fl};

`ifndef SYNTH
  a_idle_keeps_timers: assert property (@(posedge clk) disable iff (rst)
    s_accept && !produce |=> $stable(blink_on) && $stable(blink_toggle_time)
      && $stable(hazard_step) && $stable(alert_step))
    else $error("timers changed on a sample without output");

  a_hazard_clear: assert property (@(posedge clk) disable iff (rst)
    s_accept && produce && !hazard |=> hazard_step == 2'd0)
    else $error("hazard step not cleared");

  a_alert_clear: assert property (@(posedge clk) disable iff (rst)
    s_accept && produce && !hazard && alert_kind == ALERT_NONE |=> alert_step == 2'd0)
    else $error("alert step not cleared");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !advance_b |=> a_valid && $stable(a_fl) && $stable(a_rr))
    else $error("stage one word lost under stall");
`endif

endmodule

`default_nettype wire
